FILE: design/dgpg_pkg.sv
// Shared types, register indexes and color constants of the diagonal gradient generator.
package dgpg_pkg;

	localparam int COORD_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CHANNELS = 3;
	localparam int DIV_STEPS = 4;
	localparam int BORDER_PX = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [COORD_W-1:0] FRAME_WIDTH_RST = 13'd640;
	localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	localparam logic [7:0] BORDER_GRAY = 8'd235;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	localparam logic [7:0] STOP_TAB [3][3] = '{
		'{8'd30, 8'd40, 8'd120},
		'{8'd130, 8'd60, 8'd160},
		'{8'd235, 8'd170, 8'd60}
	};

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} pix_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_word_t;

endpackage

FILE: design/dgpg_div_step.sv
// One registered stage of the restoring divider, retiring several quotient bits.
module dgpg_div_step import dgpg_pkg::*; #(
	parameter int DIV_W = 13,
	parameter int NW = 32,
	parameter int STEPS = 4
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DIV_W-1:0] d,
	input  logic [DIV_W-1:0] rem_in,
	input  logic [NW-1:0]    nq_in,
	output logic [DIV_W-1:0] rem_out,
	output logic [NW-1:0]    nq_out
);

	logic [DIV_W-1:0] rem_c;
	logic [NW-1:0] nq_c;

	always_comb begin
		logic [DIV_W:0] trial;
		rem_c = rem_in;
		nq_c = nq_in;
		for (int k = 0; k < STEPS; k++) begin
			trial = {rem_c, nq_c[NW-1]};
			nq_c = {nq_c[NW-2:0], 1'b0};
			if (trial >= {1'b0, d}) begin
				trial = trial - {1'b0, d};
				nq_c[0] = 1'b1;
			end
			rem_c = trial[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= rem_c;
			nq_out <= nq_c;
		end
	end

endmodule

FILE: design/dgpg_divider.sv
// Pipelined dividers for both coordinates, with the border flag riding alongside.
module dgpg_divider import dgpg_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [COORD_W-1:0]           x,
	input  logic [COORD_W-1:0]           y,
	input  logic                         border_in,
	input  logic [COORD_W-1:0]           dw,
	input  logic [COORD_W-1:0]           dh,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [COORD_W+FRAC_BITS-1:0] qx,
	output logic [COORD_W+FRAC_BITS-1:0] qy,
	output logic                         border_out
);

	localparam int QW = COORD_W + FRAC_BITS;
	localparam int NDS = (QW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NW = NDS * DIV_STEPS;

	logic [NDS-1:0] valid_s, ready_s, border_s;
	logic [NDS-1:0] valid_prev, ready_next, border_prev;
	logic [COORD_W-1:0] remx_s [NDS+1];
	logic [COORD_W-1:0] remy_s [NDS+1];
	logic [NW-1:0] nqx_s [NDS+1];
	logic [NW-1:0] nqy_s [NDS+1];

	assign valid_prev = {valid_s[NDS-2:0], in_valid};
	assign border_prev = {border_s[NDS-2:0], border_in};
	assign ready_next = {out_ready, ready_s[NDS-1:1]};
	assign ready_s = ~valid_s | ready_next;

	assign remx_s[0] = '0;
	assign remy_s[0] = '0;
	assign nqx_s[0] = NW'(x) << FRAC_BITS;
	assign nqy_s[0] = NW'(y) << FRAC_BITS;

	for (genvar i = 0; i < NDS; i++) begin : g_stage
		dgpg_div_step #(.DIV_W(COORD_W), .NW(NW), .STEPS(DIV_STEPS)) u_step_x (
			.clk(clk), .en(ready_s[i]), .d(dw),
			.rem_in(remx_s[i]), .nq_in(nqx_s[i]),
			.rem_out(remx_s[i+1]), .nq_out(nqx_s[i+1])
		);
		dgpg_div_step #(.DIV_W(COORD_W), .NW(NW), .STEPS(DIV_STEPS)) u_step_y (
			.clk(clk), .en(ready_s[i]), .d(dh),
			.rem_in(remy_s[i]), .nq_in(nqy_s[i]),
			.rem_out(remy_s[i+1]), .nq_out(nqy_s[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= (ready_s & valid_prev) | (~ready_s & valid_s);
		end
	end

	always_ff @(posedge clk) begin
		border_s <= (ready_s & border_prev) | (~ready_s & border_s);
	end

	assign in_ready = ready_s[0];
	assign out_valid = valid_s[NDS-1];
	assign border_out = border_s[NDS-1];
	assign qx = nqx_s[NDS][QW-1:0];
	assign qy = nqy_s[NDS][QW-1:0];

endmodule

FILE: design/dgpg_blend.sv
// Three-stage color blend: diagonal position, channel products, clamping and border.
module dgpg_blend import dgpg_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [COORD_W+FRAC_BITS-1:0] qx,
	input  logic [COORD_W+FRAC_BITS-1:0] qy,
	input  logic                         border,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rgba_word_t                   word
);

	localparam int QW = COORD_W + FRAC_BITS;
	localparam int SW = QW + 1;
	localparam int PW = SW + 10;
	localparam int NUMW = PW + 1;
	localparam logic [QW-1:0] HALF = QW'(1) << (FRAC_BITS - 1);

	logic [2:0] valid_s, ready_s, ready_next, valid_prev;

	logic [SW-1:0] s_s1;
	logic lo_s1, border_s1;
	logic signed [PW-1:0] prod_s2 [CHANNELS];
	logic [7:0] base_s2 [CHANNELS];
	logic border_s2;
	rgba_word_t word_s3;

	logic [SW-1:0] s_c;
	logic lo_c;
	logic signed [PW-1:0] prod_c [CHANNELS];
	logic [7:0] base_c [CHANNELS];
	logic [7:0] chan_c [CHANNELS];

	assign valid_prev = {valid_s[1:0], in_valid};
	assign ready_next = {out_ready, ready_s[2:1]};
	assign ready_s = ~valid_s | ready_next;

	always_comb begin
		logic [QW:0] qsum;
		logic [QW-1:0] t;
		qsum = {1'b0, qx} + {1'b0, qy};
		t = qsum[QW:1];
		lo_c = (t >= HALF);
		s_c = lo_c ? {t - HALF, 1'b0} : {t, 1'b0};
	end

	always_comb begin
		logic [1:0] idx;
		logic signed [8:0] diff;
		idx = lo_s1 ? 2'd1 : 2'd0;
		for (int c = 0; c < CHANNELS; c++) begin
			base_c[c] = STOP_TAB[idx][c];
			diff = $signed({1'b0, STOP_TAB[idx + 2'd1][c]}) - $signed({1'b0, base_c[c]});
			prod_c[c] = PW'(diff) * $signed(PW'(s_s1));
		end
	end

	always_comb begin
		logic signed [NUMW-1:0] num;
		for (int c = 0; c < CHANNELS; c++) begin
			num = NUMW'(prod_s2[c]) + $signed(NUMW'(base_s2[c]) << FRAC_BITS);
			if (num[NUMW-1]) begin
				chan_c[c] = 8'd0;
			end else if (|num[NUMW-2:FRAC_BITS+8]) begin
				chan_c[c] = 8'd255;
			end else begin
				chan_c[c] = num[FRAC_BITS+7:FRAC_BITS];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= (ready_s & valid_prev) | (~ready_s & valid_s);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s[0]) begin
			s_s1 <= s_c;
			lo_s1 <= lo_c;
			border_s1 <= border;
		end
		if (ready_s[1]) begin
			prod_s2 <= prod_c;
			base_s2 <= base_c;
			border_s2 <= border_s1;
		end
		if (ready_s[2]) begin
			word_s3.red <= border_s2 ? BORDER_GRAY : chan_c[0];
			word_s3.green <= border_s2 ? BORDER_GRAY : chan_c[1];
			word_s3.blue <= border_s2 ? BORDER_GRAY : chan_c[2];
			word_s3.alpha <= ALPHA_OPAQUE;
		end
	end

	assign in_ready = ready_s[0];
	assign out_valid = valid_s[2];
	assign word = word_s3;

endmodule

FILE: design/diagonal_gradient_pattern_generator_core.sv
// Top level of the diagonal gradient pattern generator: configuration and pipeline.
//
// A pixel word (pixel_x, pixel_y) enters on the pix channel and one RGBA word
// leaves on the rgba channel for each, in order. A word is taken at a clock edge
// where valid is high and stall is low; the receiver drives stall.
// Frame width and height are written through cfg_we, cfg_index and cfg_data
// while no pixel is in flight; unknown indexes are ignored.
// Throughput is one pixel per clock while the receiver does not stall. The two
// coordinate dividers retire four quotient bits per stage, followed by three
// blend stages. Reset clears all valid bits and loads a 640 by 480 frame. When
// the receiver stalls, the result waits in the output register and the pipeline
// keeps filling its empty stages; pix_stall rises only once every stage holds a
// word.
module diagonal_gradient_pattern_generator_core import dgpg_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  pix_word_t            pix_word,
	output logic                 rgba_valid,
	input  logic                 rgba_stall,
	output rgba_word_t           rgba_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	localparam int QW = COORD_W + FRAC_BITS;

	logic [COORD_W-1:0] frame_width_q, frame_height_q, dw_q, dh_q;
	logic [COORD_W-1:0] div_c;
	logic border_c, div_ready, div_valid, div_border, blend_ready;
	logic [QW-1:0] qx, qy;

	assign div_c = (cfg_data > COORD_W'(1)) ? cfg_data - COORD_W'(1) : COORD_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			dw_q <= FRAME_WIDTH_RST - COORD_W'(1);
			dh_q <= FRAME_HEIGHT_RST - COORD_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
					dw_q <= div_c;
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
					dh_q <= div_c;
				end
				default: begin
				end
			endcase
		end
	end

	assign border_c = (pix_word.pixel_x < COORD_W'(BORDER_PX))
		|| (pix_word.pixel_y < COORD_W'(BORDER_PX))
		|| (({1'b0, pix_word.pixel_x} + (COORD_W+1)'(BORDER_PX)) >= {1'b0, frame_width_q})
		|| (({1'b0, pix_word.pixel_y} + (COORD_W+1)'(BORDER_PX)) >= {1'b0, frame_height_q});

	dgpg_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pix_valid),
		.in_ready(div_ready),
		.x(pix_word.pixel_x),
		.y(pix_word.pixel_y),
		.border_in(border_c),
		.dw(dw_q),
		.dh(dh_q),
		.out_valid(div_valid),
		.out_ready(blend_ready),
		.qx(qx),
		.qy(qy),
		.border_out(div_border)
	);

	dgpg_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(div_valid),
		.in_ready(blend_ready),
		.qx(qx),
		.qy(qy),
		.border(div_border),
		.out_valid(rgba_valid),
		.out_ready(!rgba_stall),
		.word(rgba_word)
	);

	assign pix_stall = !div_ready;

	// The input stalls only when the whole pipeline is full and the output is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (rgba_valid && rgba_stall))
		else $error("input stalled while the pipeline still had room");

	assert property (@(posedge clk) disable iff (!arst_n)
		(dw_q != '0) && (dh_q != '0))
		else $error("divisor register holds zero");

	// Inside the frame the blue channel never exceeds the violet stop.
	assert property (@(posedge clk) disable iff (!arst_n)
		rgba_valid |-> ((rgba_word.blue <= 8'd160)
			|| ((rgba_word.red == BORDER_GRAY) && (rgba_word.green == BORDER_GRAY)
			&& (rgba_word.blue == BORDER_GRAY))))
		else $error("interior pixel outside the gradient range");

endmodule

FILE: tb/testbench.sv
// Testbench of the diagonal gradient generator core: pixels checked against a predictor.
module testbench import dgpg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_W = 16;
	localparam int PIPE_DEPTH = 11;
	localparam int RESET_CYCLES = 9;
	localparam int QUIET_LIMIT = 2000;
	localparam int EDGE_PX = 2;
	localparam longint unsigned HALF_POS = 64'd1 << (FRAC_W - 1);
	localparam logic [7:0] GRAY_LEVEL = 8'd235;
	localparam logic [7:0] OPAQUE = 8'hff;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	localparam logic [7:0] GRAD_STOPS [3][3] = '{
		'{8'd30, 8'd40, 8'd120},
		'{8'd130, 8'd60, 8'd160},
		'{8'd235, 8'd170, 8'd60}
	};

	localparam int PHASES = 10;
	localparam int CALM_PHASE = 8;
	localparam int PAUSE_PHASE = 9;
	localparam int PH_W [PHASES] = '{8191, 1, 0, 5, 6, 3, 2, 8191, 100, 640};
	localparam int PH_H [PHASES] = '{8191, 1, 0, 5, 9, 4, 8191, 3, 77, 480};
	localparam int PH_ITEMS [PHASES] = '{200, 30, 30, 60, 60, 30, 60, 60, 200, 200};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_word_t pix_word = '0;
	logic rgba_valid;
	logic rgba_stall = 1'b0;
	rgba_word_t rgba_word;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;

	pix_word_t pix_pending [$];
	rgba_word_t color_queue [$];
	logic [COORD_W-1:0] frame_w = FRAME_WIDTH_RST;
	logic [COORD_W-1:0] frame_h = FRAME_HEIGHT_RST;
	logic pix_fire = 1'b0;
	bit calm = 1'b0;
	int mismatches = 0;
	int quiet_cycles = 0;
	rgba_word_t want;

	diagonal_gradient_pattern_generator_core #(
		.FRAC_BITS(FRAC_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_word(pix_word),
		.rgba_valid(rgba_valid),
		.rgba_stall(rgba_stall),
		.rgba_word(rgba_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rgba_word_t gradient_color(input pix_word_t p,
			input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
		longint unsigned dw, dh, qx, qy, pos, s;
		longint num;
		int lo, k, xi, yi, wi, hi;
		logic [7:0] mix [CHANNELS];
		bit on_border;
		rgba_word_t c;
		dw = (w > 1) ? longint'(w) - 1 : 1;
		dh = (h > 1) ? longint'(h) - 1 : 1;
		qx = (longint'(p.pixel_x) << FRAC_W) / dw;
		qy = (longint'(p.pixel_y) << FRAC_W) / dh;
		pos = (qx + qy) >> 1;
		if (pos < HALF_POS) begin
			lo = 0;
			s = pos << 1;
		end else begin
			lo = 1;
			s = (pos - HALF_POS) << 1;
		end
		for (k = 0; k < CHANNELS; k++) begin
			num = (longint'(GRAD_STOPS[lo][k]) << FRAC_W) +
				(longint'(GRAD_STOPS[lo + 1][k]) - longint'(GRAD_STOPS[lo][k])) * longint'(s);
			if (num < 0)
				mix[k] = 8'd0;
			else if ((num >>> FRAC_W) > 255)
				mix[k] = 8'd255;
			else
				mix[k] = 8'(num >>> FRAC_W);
		end
		xi = int'(p.pixel_x);
		yi = int'(p.pixel_y);
		wi = int'(w);
		hi = int'(h);
		on_border = xi < EDGE_PX || yi < EDGE_PX || xi >= wi - EDGE_PX || yi >= hi - EDGE_PX;
		c.red = on_border ? GRAY_LEVEL : mix[0];
		c.green = on_border ? GRAY_LEVEL : mix[1];
		c.blue = on_border ? GRAY_LEVEL : mix[2];
		c.alpha = OPAQUE;
		return c;
	endfunction

	function automatic logic [COORD_W-1:0] near_edge(input int lim);
		if ($urandom_range(0, 1) == 0)
			return COORD_W'($urandom_range(0, 3));
		else if (lim >= 3)
			return COORD_W'(lim - int'($urandom_range(0, 3)));
		else
			return COORD_W'($urandom_range(0, lim));
	endfunction

	function automatic pix_word_t random_pixel(input logic [COORD_W-1:0] w,
			input logic [COORD_W-1:0] h);
		pix_word_t p;
		int lx, ly, r;
		lx = (w > 0) ? int'(w) - 1 : 0;
		ly = (h > 0) ? int'(h) - 1 : 0;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			p.pixel_x = COORD_W'($urandom);
			p.pixel_y = COORD_W'($urandom);
		end else if (r < 35) begin
			p.pixel_x = near_edge(lx);
			p.pixel_y = near_edge(ly);
		end else begin
			p.pixel_x = COORD_W'($urandom_range(0, lx));
			p.pixel_y = COORD_W'($urandom_range(0, ly));
		end
		return p;
	endfunction

	task automatic add_pixel(input int x, input int y);
		pix_word_t p;
		p.pixel_x = COORD_W'(x);
		p.pixel_y = COORD_W'(y);
		pix_pending = {pix_pending, p};
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: frame_w = val;
			REG_FRAME_HEIGHT: frame_h = val;
			default: ;
		endcase
	endtask

	task automatic set_frame(input int w, input int h);
		write_reg(REG_FRAME_WIDTH, COORD_W'(w));
		write_reg(REG_SPARE_LO, COORD_W'($urandom));
		write_reg(REG_FRAME_HEIGHT, COORD_W'(h));
		write_reg(REG_SPARE_HI, COORD_W'($urandom));
	endtask

	task automatic drain();
		while (pix_pending.size() != 0 || pix_valid || color_queue.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH) @(negedge clk);
	endtask

	task automatic check_channel(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && (!pix_valid || pix_fire)) begin
			if (pix_pending.size() == 0 || (!calm && $urandom_range(0, 99) < 16)) begin
				pix_valid <= 1'b0;
			end else begin
				pix_valid <= 1'b1;
				pix_word <= pix_pending.pop_front();
			end
		end
	end

	always @(negedge clk) begin
		rgba_stall <= !calm && ($urandom_range(0, 99) < 16);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rgba_valid && !rgba_stall) begin
				if (color_queue.size() == 0) begin
					$display("%0t: rgba word expected none actual %h", $time, rgba_word);
					mismatches++;
				end else begin
					want = color_queue.pop_front();
					check_channel("red", want.red, rgba_word.red);
					check_channel("green", want.green, rgba_word.green);
					check_channel("blue", want.blue, rgba_word.blue);
					check_channel("alpha", want.alpha, rgba_word.alpha);
				end
			end
			if (pix_valid && !pix_stall)
				color_queue = {color_queue, gradient_color(pix_word, frame_w, frame_h)};
			if ((rgba_valid && !rgba_stall) || (pix_valid && !pix_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
		pix_fire <= arst_n && pix_valid && !pix_stall;
	end

	initial begin
		int ph, i, n;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// The reset frame of 640 by 480 is used before any register write.
		add_pixel(0, 0);
		add_pixel(1, 1);
		add_pixel(2, 2);
		add_pixel(2, 477);
		add_pixel(637, 2);
		add_pixel(637, 477);
		add_pixel(638, 300);
		add_pixel(300, 478);
		add_pixel(639, 479);
		add_pixel(319, 239);
		add_pixel(320, 240);
		add_pixel(319, 240);
		add_pixel(320, 239);
		add_pixel(160, 120);
		add_pixel(480, 360);
		add_pixel(3, 400);
		add_pixel(600, 5);
		add_pixel(4096, 4096);
		add_pixel(5461, 2730);
		add_pixel(8191, 0);
		add_pixel(0, 8191);
		add_pixel(8191, 8191);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			set_frame(PH_W[ph], PH_H[ph]);
			calm = (ph == CALM_PHASE);
			n = PH_ITEMS[ph];
			for (i = 0; i < n; i++) begin
				pix_pending = {pix_pending, random_pixel(frame_w, frame_h)};
				if (ph == PAUSE_PHASE && i == n / 2)
					drain();
			end
			drain();
			calm = 1'b0;
		end

		for (ph = 0; ph < 5; ph++) begin
			set_frame($urandom_range(5, 400), $urandom_range(5, 400));
			for (i = 0; i < 100; i++)
				pix_pending = {pix_pending, random_pixel(frame_w, frame_h)};
			drain();
		end

		drain();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
design/dgpg_pkg.sv
design/dgpg_div_step.sv
design/dgpg_divider.sv
design/dgpg_blend.sv
design/diagonal_gradient_pattern_generator_core.sv
tb/testbench.sv
